### src/ch8alu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ch8alu_pkg
// Shared types and constants of the register instruction unit: operation
// codes, the decoded instruction carried through the queue, queue status.
// ----------------------------------------------------------------------------
package ch8alu_pkg;

	localparam int NUM_REGS   = 16;
	localparam int BCD_DIGITS = 3;
	localparam int QDEPTH     = 2;

	localparam int REG_W   = 8;
	localparam int RIDX_W  = $clog2(NUM_REGS);
	localparam int IDX_W   = 16;
	localparam int ADDR_W  = 12;
	localparam int DIGIT_W = 4;
	localparam int CNT_W   = $clog2(BCD_DIGITS);

	localparam logic [RIDX_W-1:0] FLAG_REG = RIDX_W'(NUM_REGS - 1);

	typedef enum logic [3:0] {
		OP_LDIMM  = 4'd0,
		OP_ADDIMM = 4'd1,
		OP_COPY   = 4'd2,
		OP_OR     = 4'd3,
		OP_AND    = 4'd4,
		OP_XOR    = 4'd5,
		OP_ADD    = 4'd6,
		OP_SUB    = 4'd7,
		OP_SHR    = 4'd8,
		OP_SUBN   = 4'd9,
		OP_SHL    = 4'd10,
		OP_ADDIDX = 4'd11,
		OP_RAND   = 4'd12,
		OP_BCD    = 4'd13,
		OP_SETIDX = 4'd14
	} op_e;

	typedef struct packed {
		op_e               op;
		logic [RIDX_W-1:0] x;
		logic [RIDX_W-1:0] y;
		logic [REG_W-1:0]  nn;
		logic [ADDR_W-1:0] addr;
		logic [REG_W-1:0]  rnd;
		logic              wr_vx;
		logic              wr_flag;
		logic              wr_idx;
		logic              is_bcd;
	} instr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage
`default_nettype wire

### src/chip8_register_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_register_alu
// Register instruction unit: sixteen byte registers and a 16-bit index,
// one instruction request in, one result (three for decimal split) out.
// ----------------------------------------------------------------------------
// One instruction is taken per clock and one result leaves per clock while
// the result side does not stall; the execute stage sets that figure, and
// decimal split holds its instruction there for one result per digit. A
// request passes the decode register, queue, register file read stage and
// output register on its way to the result port. The output register holds
// a waiting result and stalls the execute stage, and the two-entry queue
// lets the input side run on while the result side stalls. Registers and
// index come out of reset at zero, with no clearing pass.
module chip8_register_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // reg_x, reg_y, imm_byte, imm_addr, random_byte
	input  wire logic [3:0]  s_tuser,  // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // vx_value, flag_value, index_value, mem_addr, mem_data
	output logic             m_tuser,  // mem_write
	output logic             m_tlast
);

	ch8alu_pkg::instr_t dec;
	ch8alu_pkg::instr_t head;
	ch8alu_pkg::qstat_t qstat;
	logic q_push, q_pop;

	logic [ch8alu_pkg::REG_W-1:0]   vx_value, flag_value;
	logic [ch8alu_pkg::IDX_W-1:0]   index_value, mem_addr;
	logic [ch8alu_pkg::DIGIT_W-1:0] mem_data;

	ch8alu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.operation   (s_tuser),
		.reg_x       (s_tdata[3:0]),
		.reg_y       (s_tdata[7:4]),
		.imm_byte    (s_tdata[15:8]),
		.imm_addr    (s_tdata[27:16]),
		.random_byte (s_tdata[35:28]),
		.qstat       (qstat),
		.push        (q_push),
		.dec         (dec)
	);

	ch8alu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_instr (dec),
		.pop      (q_pop),
		.head     (head),
		.qstat    (qstat)
	);

	ch8alu_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!qstat.empty),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.vx_value    (vx_value),
		.flag_value  (flag_value),
		.index_value (index_value),
		.mem_write   (m_tuser),
		.mem_addr    (mem_addr),
		.mem_data    (mem_data),
		.last        (m_tlast)
	);

	assign m_tdata = {4'b0, mem_data, mem_addr, index_value, flag_value, vx_value};

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("queue push while full");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qstat.empty)
		else $error("queue pop while empty");

	a_split_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> m_tuser)
		else $error("non-final result that is not a digit write");

	a_digit_next: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && m_tuser && m_tdata[47:32] == $past(m_tdata[47:32]) + 16'd1))
		else $error("digit write sequence broken");

endmodule
`default_nettype wire

### src/ch8alu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ch8alu_front
// Takes instruction requests, classifies them by the state they write and
// holds the decoded instruction until the queue takes it.
// ----------------------------------------------------------------------------
module ch8alu_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [3:0]          operation,
	input  wire logic [ch8alu_pkg::RIDX_W-1:0] reg_x,
	input  wire logic [ch8alu_pkg::RIDX_W-1:0] reg_y,
	input  wire logic [ch8alu_pkg::REG_W-1:0]  imm_byte,
	input  wire logic [ch8alu_pkg::ADDR_W-1:0] imm_addr,
	input  wire logic [ch8alu_pkg::REG_W-1:0]  random_byte,
	input  wire ch8alu_pkg::qstat_t  qstat,
	output logic                     push,
	output ch8alu_pkg::instr_t       dec
);

	logic               valid_s1;
	ch8alu_pkg::instr_t instr_s1;
	ch8alu_pkg::instr_t dec_next;

	always_comb begin
		dec_next         = '0;
		dec_next.op      = ch8alu_pkg::op_e'(operation);
		dec_next.x       = reg_x;
		dec_next.y       = reg_y;
		dec_next.nn      = imm_byte;
		dec_next.addr    = imm_addr;
		dec_next.rnd     = random_byte;
		unique case (operation) inside
			ch8alu_pkg::OP_LDIMM, ch8alu_pkg::OP_ADDIMM, ch8alu_pkg::OP_COPY,
			ch8alu_pkg::OP_OR, ch8alu_pkg::OP_AND, ch8alu_pkg::OP_XOR,
			ch8alu_pkg::OP_RAND: begin
				dec_next.wr_vx = 1'b1;
			end
			ch8alu_pkg::OP_ADD, ch8alu_pkg::OP_SUB, ch8alu_pkg::OP_SHR,
			ch8alu_pkg::OP_SUBN, ch8alu_pkg::OP_SHL: begin
				dec_next.wr_vx   = 1'b1;
				dec_next.wr_flag = 1'b1;
			end
			ch8alu_pkg::OP_ADDIDX, ch8alu_pkg::OP_SETIDX: begin
				dec_next.wr_idx = 1'b1;
			end
			ch8alu_pkg::OP_BCD: begin
				dec_next.is_bcd = 1'b1;
			end
			default: begin
				dec_next.wr_vx = 1'b0;
			end
		endcase
	end

	assign push     = valid_s1 && !qstat.full;
	assign in_ready = !valid_s1 || push;
	assign dec      = instr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			instr_s1 <= dec_next;
		end
	end

endmodule
`default_nettype wire

### src/ch8alu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ch8alu_queue
// Short first-in first-out queue of decoded instructions between the front
// and the execute side, head shown ahead of the pop.
// ----------------------------------------------------------------------------
module ch8alu_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ch8alu_pkg::instr_t wr_instr,
	input  wire logic               pop,
	output ch8alu_pkg::instr_t      head,
	output ch8alu_pkg::qstat_t      qstat
);

	localparam int PTR_W = (ch8alu_pkg::QDEPTH > 1) ? $clog2(ch8alu_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(ch8alu_pkg::QDEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ch8alu_pkg::QDEPTH - 1);

	ch8alu_pkg::instr_t entries_q [ch8alu_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head        = entries_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(ch8alu_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_instr;
		end
	end

endmodule
`default_nettype wire

### src/ch8alu_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ch8alu_exec
// Execute side: register file read stage, byte alu, index update, decimal
// split sequencer and the output register.
// ----------------------------------------------------------------------------
module ch8alu_exec (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ch8alu_pkg::instr_t                  head,
	input  wire logic                                head_valid,
	output logic                                     pop,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [ch8alu_pkg::REG_W-1:0]             vx_value,
	output logic [ch8alu_pkg::REG_W-1:0]             flag_value,
	output logic [ch8alu_pkg::IDX_W-1:0]             index_value,
	output logic                                     mem_write,
	output logic [ch8alu_pkg::IDX_W-1:0]             mem_addr,
	output logic [ch8alu_pkg::DIGIT_W-1:0]           mem_data,
	output logic                                     last
);

	localparam int RW = ch8alu_pkg::REG_W;
	localparam int AW = ch8alu_pkg::RIDX_W;
	localparam int IW = ch8alu_pkg::IDX_W;
	localparam int DW = ch8alu_pkg::DIGIT_W;
	localparam int CW = ch8alu_pkg::CNT_W;
	localparam logic [CW-1:0] LAST_DIGIT = CW'(ch8alu_pkg::BCD_DIGITS - 1);

	function automatic logic [3*DW-1:0] bcd_split(input logic [RW-1:0] v);
		logic [1:0]  hund;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [DW-1:0] tens;
		logic [6:0]  ones;
		if (v >= RW'(200)) begin
			hund = 2'd2;
			rem  = 7'(v - RW'(200));
		end else if (v >= RW'(100)) begin
			hund = 2'd1;
			rem  = 7'(v - RW'(100));
		end else begin
			hund = 2'd0;
			rem  = 7'(v);
		end
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones = rem - 7'(tens) * 7'd10;
		return {ones[DW-1:0], tens, DW'(hund)};
	endfunction

	// register file
	logic [RW-1:0] regs_mem [ch8alu_pkg::NUM_REGS];
	logic [ch8alu_pkg::NUM_REGS-1:0] vld_q;
	logic [RW-1:0] rd_x_q, rd_y_q;
	logic          rdv_x_q, rdv_y_q;
	logic [AW-1:0] rd_xa, rd_ya;

	// last write, for the read that coincides with it
	logic          wr_valid_q;
	logic [AW-1:0] wr_addr_q;
	logic [RW-1:0] wr_data_q;

	logic [RW-1:0] flag_q;
	logic [IW-1:0] index_q;

	logic               valid_s1;
	ch8alu_pkg::instr_t ins_s1;
	logic [CW-1:0]      cnt_q;

	logic out_valid_q;
	logic out_free, fire, complete, adv, we;

	logic [RW-1:0] vx, vy, res, flag_new, vx_out;
	logic          fl;
	logic [RW:0]   sum9;
	logic [IW-1:0] idx_new, idx_out;
	logic [3*DW-1:0] digits;
	logic [DW-1:0] digit;

	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && out_free;
	assign complete = fire && (!ins_s1.is_bcd || cnt_q == LAST_DIGIT);
	assign adv      = !valid_s1 || complete;
	assign pop      = adv && head_valid;
	assign we       = complete && ins_s1.wr_vx;

	assign rd_xa = adv ? head.x : ins_s1.x;
	assign rd_ya = adv ? head.y : ins_s1.y;

	always_comb begin
		if (ins_s1.x == ch8alu_pkg::FLAG_REG) begin
			vx = flag_q;
		end else if (wr_valid_q && wr_addr_q == ins_s1.x) begin
			vx = wr_data_q;
		end else begin
			vx = rdv_x_q ? rd_x_q : '0;
		end
		if (ins_s1.y == ch8alu_pkg::FLAG_REG) begin
			vy = flag_q;
		end else if (wr_valid_q && wr_addr_q == ins_s1.y) begin
			vy = wr_data_q;
		end else begin
			vy = rdv_y_q ? rd_y_q : '0;
		end
	end

	always_comb begin
		res     = vx;
		fl      = 1'b0;
		sum9    = {1'b0, vx} + {1'b0, vy};
		idx_new = index_q;
		case (ins_s1.op)
			ch8alu_pkg::OP_LDIMM:  res = ins_s1.nn;
			ch8alu_pkg::OP_ADDIMM: res = vx + ins_s1.nn;
			ch8alu_pkg::OP_COPY:   res = vy;
			ch8alu_pkg::OP_OR:     res = vx | vy;
			ch8alu_pkg::OP_AND:    res = vx & vy;
			ch8alu_pkg::OP_XOR:    res = vx ^ vy;
			ch8alu_pkg::OP_ADD: begin
				res = sum9[RW-1:0];
				fl  = sum9[RW];
			end
			ch8alu_pkg::OP_SUB: begin
				res = vx - vy;
				fl  = vx > vy;
			end
			ch8alu_pkg::OP_SHR: begin
				res = vx >> 1;
				fl  = vx[0];
			end
			ch8alu_pkg::OP_SUBN: begin
				res = vy - vx;
				fl  = vy > vx;
			end
			ch8alu_pkg::OP_SHL: begin
				res = vx << 1;
				fl  = vx[RW-1];
			end
			ch8alu_pkg::OP_ADDIDX: idx_new = index_q + IW'(vx);
			ch8alu_pkg::OP_RAND:   res = ins_s1.rnd & ins_s1.nn;
			ch8alu_pkg::OP_SETIDX: idx_new = IW'(ins_s1.addr);
			default:               res = vx;
		endcase
	end

	always_comb begin
		if (ins_s1.wr_vx && ins_s1.x == ch8alu_pkg::FLAG_REG) begin
			flag_new = res;
		end else if (ins_s1.wr_flag) begin
			flag_new = RW'(fl);
		end else begin
			flag_new = flag_q;
		end
		if (ins_s1.wr_vx) begin
			vx_out = res;
		end else if (ins_s1.x == ch8alu_pkg::FLAG_REG) begin
			vx_out = flag_new;
		end else begin
			vx_out = vx;
		end
		idx_out = ins_s1.wr_idx ? idx_new : index_q;
		digits  = bcd_split(vx);
		case (cnt_q)
			2'd0:    digit = digits[DW-1:0];
			2'd1:    digit = digits[2*DW-1:DW];
			default: digit = digits[3*DW-1:2*DW];
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			regs_mem[ins_s1.x] <= res;
		end
		rd_x_q <= regs_mem[rd_xa];
		rd_y_q <= regs_mem[rd_ya];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rdv_x_q    <= 1'b0;
			rdv_y_q    <= 1'b0;
			wr_valid_q <= 1'b0;
			wr_addr_q  <= '0;
			wr_data_q  <= '0;
			flag_q     <= '0;
			index_q    <= '0;
			valid_s1   <= 1'b0;
			cnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_x_q    <= vld_q[rd_xa];
			rdv_y_q    <= vld_q[rd_ya];
			wr_valid_q <= we;
			if (we) begin
				vld_q[ins_s1.x] <= 1'b1;
				wr_addr_q       <= ins_s1.x;
				wr_data_q       <= res;
			end
			if (complete) begin
				flag_q  <= flag_new;
				index_q <= idx_out;
			end
			if (adv) begin
				valid_s1 <= head_valid;
			end
			if (fire && ins_s1.is_bcd) begin
				cnt_q <= (cnt_q == LAST_DIGIT) ? '0 : cnt_q + CW'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ins_s1 <= head;
		end
		if (fire) begin
			vx_value    <= vx_out;
			flag_value  <= flag_new;
			index_value <= idx_out;
			if (ins_s1.is_bcd) begin
				mem_write <= 1'b1;
				mem_addr  <= index_q + IW'(cnt_q);
				mem_data  <= digit;
				last      <= (cnt_q == LAST_DIGIT);
			end else begin
				mem_write <= 1'b0;
				mem_addr  <= '0;
				mem_data  <= '0;
				last      <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the register instruction unit. A behavioural copy
// of the register file and index predicts every result of each accepted
// request. Results are checked in order, field by field, while both stream
// sides idle at random and the result side once holds off for a long spell.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [3:0] OP_UNUSED   = 4'd15;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         HOLD_CYCLES = 120;
	localparam int         SETTLE      = 16;
	localparam int         RANDOM_REQS = 166;

	typedef struct {
		logic [7:0]  vx;
		logic [7:0]  flag;
		logic [15:0] index;
		logic        wr;
		logic [15:0] maddr;
		logic [3:0]  digit;
		logic        last;
	} alu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic [7:0]  vreg [ch8alu_pkg::NUM_REGS];
	logic [15:0] index_reg;
	alu_result_t expected_results [$];

	int  mismatches = 0;
	int  cycles = 0;
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	bit  hold_req = 1'b0;

	chip8_register_alu i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// behavioural register file: executes one request, queues its results
	task automatic execute_instr(input logic [3:0] op, input logic [39:0] fields);
		logic [3:0]  x;
		logic [3:0]  y;
		logic [7:0]  nn;
		logic [11:0] addr;
		logic [7:0]  rnd;
		logic [7:0]  vx;
		logic [7:0]  vy;
		logic [8:0]  sum;
		alu_result_t res;
		x    = fields[3:0];
		y    = fields[7:4];
		nn   = fields[15:8];
		addr = fields[27:16];
		rnd  = fields[35:28];
		vx   = vreg[x];
		vy   = vreg[y];
		if (op == ch8alu_pkg::OP_BCD) begin
			for (int k = 0; k < ch8alu_pkg::BCD_DIGITS; k++) begin
				res.vx    = vreg[x];
				res.flag  = vreg[ch8alu_pkg::FLAG_REG];
				res.index = index_reg;
				res.wr    = 1'b1;
				res.maddr = index_reg + 16'(k);
				res.digit = (k == 0) ? 4'(vx / 100) : (k == 1) ? 4'((vx / 10) % 10)
					: 4'(vx % 10);
				res.last  = (k == ch8alu_pkg::BCD_DIGITS - 1);
				expected_results.push_back(res);
			end
		end else begin
			case (op)
				ch8alu_pkg::OP_LDIMM:  vreg[x] = nn;
				ch8alu_pkg::OP_ADDIMM: vreg[x] = vx + nn;
				ch8alu_pkg::OP_COPY:   vreg[x] = vy;
				ch8alu_pkg::OP_OR:     vreg[x] = vx | vy;
				ch8alu_pkg::OP_AND:    vreg[x] = vx & vy;
				ch8alu_pkg::OP_XOR:    vreg[x] = vx ^ vy;
				ch8alu_pkg::OP_ADD: begin
					sum = {1'b0, vx} + {1'b0, vy};
					vreg[ch8alu_pkg::FLAG_REG] = {7'd0, sum[8]};
					vreg[x] = sum[7:0];
				end
				ch8alu_pkg::OP_SUB: begin
					vreg[ch8alu_pkg::FLAG_REG] = {7'd0, vx > vy};
					vreg[x] = vx - vy;
				end
				ch8alu_pkg::OP_SHR: begin
					vreg[ch8alu_pkg::FLAG_REG] = {7'd0, vx[0]};
					vreg[x] = vx >> 1;
				end
				ch8alu_pkg::OP_SUBN: begin
					vreg[ch8alu_pkg::FLAG_REG] = {7'd0, vy > vx};
					vreg[x] = vy - vx;
				end
				ch8alu_pkg::OP_SHL: begin
					vreg[ch8alu_pkg::FLAG_REG] = {7'd0, vx[7]};
					vreg[x] = vx << 1;
				end
				ch8alu_pkg::OP_ADDIDX: index_reg = index_reg + {8'd0, vx};
				ch8alu_pkg::OP_RAND:   vreg[x] = rnd & nn;
				ch8alu_pkg::OP_SETIDX: index_reg = {4'd0, addr};
				default: ;
			endcase
			res.vx    = vreg[x];
			res.flag  = vreg[ch8alu_pkg::FLAG_REG];
			res.index = index_reg;
			res.wr    = 1'b0;
			res.maddr = '0;
			res.digit = '0;
			res.last  = 1'b1;
			expected_results.push_back(res);
		end
	endtask

	task automatic check_result();
		alu_result_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: tdata=%h tuser=%b tlast=%b",
					m_tdata, m_tuser, m_tlast);
			return;
		end
		want = expected_results.pop_front();
		if (m_tdata[7:0] !== want.vx || m_tdata[15:8] !== want.flag ||
				m_tdata[31:16] !== want.index || m_tuser !== want.wr ||
				m_tdata[47:32] !== want.maddr || m_tdata[51:48] !== want.digit ||
				m_tlast !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: expected vx=%h vf=%h i=%h wr=%b addr=%h d=%h last=%b,",
					" got vx=%h vf=%h i=%h wr=%b addr=%h d=%h last=%b"},
					want.vx, want.flag, want.index, want.wr, want.maddr, want.digit,
					want.last, m_tdata[7:0], m_tdata[15:8], m_tdata[31:16], m_tuser,
					m_tdata[47:32], m_tdata[51:48], m_tlast);
		end
	endtask

	// results are checked before the request of the same edge is predicted
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		if (m_tvalid && m_tready)
			check_result();
		if (arst_n && s_tvalid && s_tready)
			execute_instr(s_tuser, s_tdata);
	end

	// result side: ready follows a stall pattern that is redrawn periodically
	initial begin
		int mode;
		logic [7:0] mask;
		mode = 0;
		mask = 8'hff;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (cycles % 48 == 0) begin
				mode = $urandom_range(0, 3);
				mask = 8'($urandom);
			end
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= mask[cycles % 8];
			endcase
		end
	end

	task automatic send_instr(input logic [3:0] op, input logic [3:0] x,
			input logic [3:0] y, input logic [7:0] nn, input logic [11:0] addr,
			input logic [7:0] rnd);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'd0, rnd, addr, nn, y, x};
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic test_reset_state();
		send_instr(OP_UNUSED, 4'd3, 4'd9, 8'h5a, 12'h123, 8'h77);
		send_instr(ch8alu_pkg::OP_BCD, 4'd0, 4'd0, 8'h00, 12'h000, 8'h00);
	endtask

	task automatic test_all_ops();
		send_instr(ch8alu_pkg::OP_LDIMM, 4'd1, 4'd0, 8'hff, 12'hfff, 8'hff);
		send_instr(ch8alu_pkg::OP_LDIMM, 4'd2, 4'd0, 8'h01, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_ADD, 4'd1, 4'd2, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_ADDIMM, 4'd1, 4'd0, 8'hff, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SUB, 4'd2, 4'd1, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SUBN, 4'd3, 4'd1, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SHR, 4'd1, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SHL, 4'd3, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_OR, 4'd4, 4'd3, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_AND, 4'd4, 4'd1, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_XOR, 4'd4, 4'd3, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_COPY, 4'd5, 4'd3, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_RAND, 4'd6, 4'd0, 8'hf0, 12'h000, 8'hab);
		send_instr(ch8alu_pkg::OP_SETIDX, 4'd0, 4'd0, 8'h00, 12'hfff, 8'h00);
		send_instr(ch8alu_pkg::OP_BCD, 4'd3, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_ADDIDX, 4'd3, 4'd0, 8'h00, 12'h000, 8'h00);
	endtask

	// flag-setting ops and a load with the flag register as destination
	task automatic test_flag_as_dest();
		send_instr(ch8alu_pkg::OP_ADD, 4'd15, 4'd3, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_LDIMM, 4'd15, 4'd0, 8'h80, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SHL, 4'd15, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SUBN, 4'd15, 4'd3, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SHR, 4'd15, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SUB, 4'd15, 4'd15, 8'h00, 12'h000, 8'h00);
	endtask

	// index from 0x0fff up past 0xffff, with a digit write straddling the wrap
	task automatic test_index_wrap();
		gaps_on = 1'b0;
		send_instr(ch8alu_pkg::OP_LDIMM, 4'd0, 4'd0, 8'hff, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_SETIDX, 4'd0, 4'd0, 8'h00, 12'hfff, 8'h00);
		repeat (240)
			send_instr(ch8alu_pkg::OP_ADDIDX, 4'd0, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_LDIMM, 4'd1, 4'd0, 8'd239, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_ADDIDX, 4'd1, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_BCD, 4'd0, 4'd0, 8'h00, 12'h000, 8'h00);
		send_instr(ch8alu_pkg::OP_ADDIDX, 4'd0, 4'd0, 8'h00, 12'h000, 8'h00);
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_req = 1'b1;
		for (int n = 0; n < 24; n++)
			send_instr((n % 3 == 0) ? ch8alu_pkg::OP_BCD : 4'($urandom_range(0, 14)),
				4'($urandom), 4'($urandom), 8'($urandom), 12'($urandom), 8'($urandom));
		gaps_on = 1'b1;
	endtask

	task automatic test_random();
		int pick;
		logic [3:0] op;
		logic [7:0] nn;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				op = ch8alu_pkg::OP_LDIMM;
			else if (pick == 99)
				op = OP_UNUSED;
			else
				op = 4'($urandom_range(1, 14));
			case ($urandom_range(0, 7))
				0: nn = 8'h00;
				1: nn = 8'hff;
				default: nn = 8'($urandom);
			endcase
			send_instr(op, 4'($urandom), 4'($urandom), nn, 12'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < ch8alu_pkg::NUM_REGS; r++)
			vreg[r] = '0;
		index_reg = '0;
		test_reset_state();
		test_all_ops();
		test_flag_as_dest();
		test_index_wrap();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0 || hold_req)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
